### rtl/lkq_pkg.sv
package lkq_pkg;

  localparam int CAPACITY_DEFAULT = 16;
  localparam int KEY_W = 8;
  localparam int ACT_W = 2;
  localparam int OCC_W = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_NEW     = 2'd0,
    ACT_AT_REAR = 2'd1,
    ACT_MOVED   = 2'd2,
    ACT_EVICT   = 2'd3
  } action_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic accept;
    logic evict;
  } lkq_ctl_t;

endpackage

### rtl/lru_key_queue.sv
// The result is registered and appears in the cycle after its key transaction is accepted.
// Throughput: one key per cycle; every cell compares and shifts in the same cycle.
// The result register frees the input whenever the held result is taken.
// Reset (rst, synchronous) empties the queue and drops any held result;
// stored keys are left as they are and ignored until rewritten.
module lru_key_queue
  import lkq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             key_valid,
  output logic             key_stall,
  input  logic [KEY_W-1:0] key,
  output logic             res_valid,
  input  logic             res_stall,
  output logic [ACT_W-1:0] action,
  output logic [KEY_W-1:0] evicted_key,
  output logic [OCC_W-1:0] occupancy
);

  localparam int COUNT_W = $clog2(CAPACITY + 1);

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic [COUNT_W-1:0] tail;
  logic               accept;
  logic               found;
  logic               full;
  logic               at_rear;
  lkq_ctl_t           ctl;
  action_t            action_next;

  logic [CAPACITY:0]   seen;
  logic [CAPACITY-1:0] rear_hits;
  logic [KEY_W-1:0]    entries [CAPACITY];

  assign key_stall = res_valid && res_stall;
  assign accept    = key_valid && !key_stall;

  assign full       = count == COUNT_W'(CAPACITY);
  assign found      = seen[CAPACITY];
  assign at_rear    = |rear_hits;
  assign tail       = (found || full) ? count - COUNT_W'(1) : count;
  assign count_next = (found || full) ? count : count + COUNT_W'(1);

  assign ctl.accept = accept;
  assign ctl.evict  = !found && full;
  assign seen[0]    = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0] nbr;
    if (i == CAPACITY - 1) begin : g_last
      assign nbr = entries[i];
    end else begin : g_mid
      assign nbr = entries[i+1];
    end
    lkq_cell #(
      .INDEX   (i),
      .COUNT_W (COUNT_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .key        (key),
      .count      (count),
      .tail       (tail),
      .next_entry (nbr),
      .seen_in    (seen[i]),
      .seen_out   (seen[i+1]),
      .rear_hit   (rear_hits[i]),
      .entry      (entries[i])
    );
  end

  always_comb begin
    if (ctl.evict) begin
      action_next = ACT_EVICT;
    end else if (found && at_rear) begin
      action_next = ACT_AT_REAR;
    end else if (found) begin
      action_next = ACT_MOVED;
    end else begin
      action_next = ACT_NEW;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action      <= action_next;
      evicted_key <= ctl.evict ? entries[0] : '0;
      occupancy   <= OCC_W'(count_next);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(CAPACITY))
    else $error("count above capacity");

  a_empty_new: assert property (@(posedge clk) disable iff (rst)
    accept && count == '0 |=> res_valid && action == ACT_NEW)
    else $error("empty queue did not report a new key");

  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    accept && !full |=> action != ACT_EVICT)
    else $error("eviction from a queue that was not full");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    accept |=> count == $past(count) || count == $past(count) + COUNT_W'(1))
    else $error("count changed by more than one");

  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && action != ACT_EVICT |-> evicted_key == '0)
    else $error("evicted key set without eviction");
`endif

endmodule

### rtl/lkq_cell.sv
module lkq_cell
  import lkq_pkg::*;
#(
  parameter int INDEX   = 0,
  parameter int COUNT_W = 5
) (
  input  logic               clk,
  input  lkq_ctl_t           ctl,
  input  logic [KEY_W-1:0]   key,
  input  logic [COUNT_W-1:0] count,
  input  logic [COUNT_W-1:0] tail,
  input  logic [KEY_W-1:0]   next_entry,
  input  logic               seen_in,
  output logic               seen_out,
  output logic               rear_hit,
  output logic [KEY_W-1:0]   entry
);

  logic             live;
  logic             hit;
  logic             load;
  logic             shift;
  logic [KEY_W-1:0] entry_next;

  assign live     = COUNT_W'(INDEX) < count;
  assign hit      = live && (entry == key);
  assign seen_out = seen_in | hit;
  assign load     = tail == COUNT_W'(INDEX);
  // Cells from the hit onward (or all on eviction) take the neighbor's key
  assign shift    = seen_out | ctl.evict;
  assign rear_hit = hit && load;

  always_comb begin
    if (load) begin
      entry_next = key;
    end else if (shift) begin
      entry_next = next_entry;
    end else begin
      entry_next = entry;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      entry <= entry_next;
    end
  end

endmodule

### tb/sv/lru_key_queue_tb.sv
`timescale 1ns / 1ps

module lru_key_queue_tb;
  import lkq_pkg::*;

  localparam int CAP = CAPACITY_DEFAULT;
  localparam int CYCLE_LIMIT = 400000;
  localparam int KEYS_PER_PHASE = 385;

  typedef struct packed {
    action_t          act;
    logic [KEY_W-1:0] evicted;
    logic [OCC_W-1:0] occ;
  } lru_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             key_valid = 1'b0;
  logic             key_stall;
  logic [KEY_W-1:0] key = '0;
  logic             res_valid;
  logic             res_stall = 1'b0;
  logic [ACT_W-1:0] action;
  logic [KEY_W-1:0] evicted_key;
  logic [OCC_W-1:0] occupancy;

  logic [KEY_W-1:0] pending_keys[$];
  lru_result_t      expected_results[$];
  lru_result_t      oldest_result;

  // shadow of the queue contents, front at index 0
  logic [KEY_W-1:0] held_keys[CAP];
  int               held_count = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int cycle_count = 0;

  lru_key_queue #(.CAPACITY(CAP)) dut (
    .clk         (clk),
    .rst         (rst),
    .key_valid   (key_valid),
    .key_stall   (key_stall),
    .key         (key),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .action      (action),
    .evicted_key (evicted_key),
    .occupancy   (occupancy)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic lru_result_t lru_reference(input logic [KEY_W-1:0] ref_key);
    lru_result_t r;
    int          hit;
    int          i;
    r.act = ACT_NEW;
    r.evicted = '0;
    hit = -1;
    for (i = 0; i < held_count; i++) begin
      if (hit < 0 && held_keys[i] == ref_key) hit = i;
    end
    if (hit >= 0 && hit == held_count - 1) begin
      r.act = ACT_AT_REAR;
    end else if (hit >= 0) begin
      // pull the key out and close the gap
      for (i = hit; i < held_count - 1; i++) held_keys[i] = held_keys[i + 1];
      held_keys[held_count - 1] = ref_key;
      r.act = ACT_MOVED;
    end else if (held_count >= CAP) begin
      r.evicted = held_keys[0];
      for (i = 0; i < CAP - 1; i++) held_keys[i] = held_keys[i + 1];
      held_keys[CAP - 1] = ref_key;
      r.act = ACT_EVICT;
    end else begin
      held_keys[held_count] = ref_key;
      held_count++;
    end
    r.occ = held_count[OCC_W-1:0];
    return r;
  endfunction

  // driver: predict on acceptance, then advance or hold
  always @(posedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
    end else begin
      if (key_valid && !key_stall) expected_results.push_back(lru_reference(key));
      if (!key_valid || !key_stall) begin
        if (pending_keys.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          key_valid <= 1'b1;
          key <= pending_keys.pop_front();
        end else begin
          key_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result transaction against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: action %0d evicted_key %0d occupancy %0d",
                 action, evicted_key, occupancy);
          fail_count++;
        end else begin
          oldest_result = expected_results.pop_front();
          if (action !== oldest_result.act) begin
            $error("action: expected %0d, got %0d", oldest_result.act, action);
            fail_count++;
          end
          if (evicted_key !== oldest_result.evicted) begin
            $error("evicted_key: expected %0d, got %0d", oldest_result.evicted, evicted_key);
            fail_count++;
          end
          if (occupancy !== oldest_result.occ) begin
            $error("occupancy: expected %0d, got %0d", oldest_result.occ, occupancy);
            fail_count++;
          end
        end
      end
      res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_keys.size() != 0 || key_valid || expected_results.size() != 0);
  endtask

  initial begin
    logic [KEY_W-1:0] next_key;
    logic [KEY_W-1:0] prev_key;
    logic [KEY_W-1:0] pool_base;
    int               pool_span;
    int               pick;
    int               phase;
    int               n;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty list, repeat at rear, move from front, then fill to capacity
    pending_keys = '{8'h00, 8'h00, 8'hFF, 8'h00,
                     8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
                     8'h55, 8'hAA, 8'h7F, 8'hFE, 8'h0F, 8'hF0};
    // full list: miss evicts, hit moves, hit at rear stays, miss evicts again
    pending_keys.push_back(8'h33);
    pending_keys.push_back(8'h00);
    pending_keys.push_back(8'h00);
    pending_keys.push_back(8'h99);
    // hold the sender until every result is back
    wait_drained();

    prev_key = '0;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 45;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 45;
        end
        default: begin
          send_idle_pct = 15;
          recv_stall_pct = 15;
        end
      endcase
      // a pool a little smaller or larger than capacity mixes hits and evictions
      pool_base = KEY_W'($urandom_range(0, 255));
      pool_span = $urandom_range(12, 24);
      for (n = 0; n < KEYS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) next_key = KEY_W'($urandom_range(0, 255));
        else if (pick < 30) next_key = prev_key;
        else next_key = pool_base + KEY_W'($urandom_range(0, pool_span - 1));
        pending_keys.push_back(next_key);
        prev_key = next_key;
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
